### rtl/core/moving_average_ring_macros.svh
// Assertion macros for the moving average block.
// Used by the top level only; clk and arst_n must be in scope where expanded.
`ifndef MOVING_AVERAGE_RING_MACROS_SVH
`define MOVING_AVERAGE_RING_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MAR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define MAR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/mar_pkg.sv
// Package for the moving average block: sizes and payload types.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package mar_pkg;

	localparam int MAX_WINDOW  = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int WL_BITS     = 7;
	localparam int POS_BITS    = $clog2(MAX_WINDOW);
	// |sum| <= MAX_WINDOW * 2^(SAMPLE_BITS-1), so one bit above that magnitude
	localparam int MAG_BITS    = $clog2(MAX_WINDOW) + SAMPLE_BITS;
	localparam int SUM_BITS    = MAG_BITS;
	localparam int CNT_BITS    = $clog2(MAG_BITS);
	// remainder of the division stays below the window length
	localparam int REM_BITS    = $clog2(MAX_WINDOW + 1);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [SUM_BITS-1:0]    sum_t;
	typedef logic        [MAG_BITS-1:0]    mag_t;
	typedef logic        [WL_BITS-1:0]     wlen_t;
	typedef logic        [POS_BITS-1:0]    pos_t;

endpackage

`default_nettype wire

### rtl/core/mar_channels.sv
// Valid/ready channel interfaces of the moving average block.
// Depends on mar_pkg for the payload types.
`default_nettype none

// Sample input channel
interface mar_sample_if;
	logic             valid;
	logic             ready;
	mar_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// Result output channel
interface mar_result_if;
	logic             valid;
	logic             ready;
	logic             ready_res;
	mar_pkg::sample_t average;

	modport source (output valid, output ready_res, output average, input ready);
	modport sink (input valid, input ready_res, input average, output ready);
endinterface

// Window length write channel
interface mar_cfg_if;
	logic           valid;
	logic           ready;
	mar_pkg::wlen_t window_length;

	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

`default_nettype wire

### rtl/core/moving_average_ring.sv
// Moving average over a ring of recent samples, with a bit-serial divider.
// Depends on mar_pkg, the channels in mar_channels.sv and the assertion macros.
//
// Usage:
//   samples : one signed sample per beat (valid/ready).
//   results : one beat per sample: ready_res and the held average.
//   cfg     : writes window_length (0..64, above 64 acts as 64, 0 disables).
//             Always ready; a write clears ring, position, sum, flag, average.
//             Write only while no sample is in flight.
// Timing:
//   A sample is taken together with the old ring entry at its position; the
//   sum is updated in ST_READ, then the restoring divider runs one quotient
//   bit per cycle in ST_DIV, and the result is loaded in ST_WAIT once the
//   output register is free. ST_DIV is skipped while the window is still
//   filling, and ST_READ too when disabled. One sample is worked on at a time;
//   the next is accepted as soon as the previous result is in the output register.
// Reset: window_length returns to 8, the ring reads as zero (per-entry valid
//   bits), nothing is pending.
// Stall: a stalled result holds in the output register; a finished sample
//   waits until that register frees, and no new sample is taken meanwhile.
`default_nettype none

module moving_average_ring (
	input  wire           clk,
	input  wire           arst_n,
	mar_sample_if.sink    samples,
	mar_result_if.source  results,
	mar_cfg_if.sink       cfg
);

	`include "moving_average_ring_macros.svh"

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_WAIT = 2'd3;

	localparam int SX = mar_pkg::SUM_BITS - mar_pkg::SAMPLE_BITS;

	logic [1:0]                      state_q;
	mar_pkg::wlen_t                  wl_q;
	logic [mar_pkg::MAX_WINDOW-1:0]  valid_q;
	mar_pkg::sample_t                mem [mar_pkg::MAX_WINDOW];
	mar_pkg::sample_t                rd_q;
	mar_pkg::sample_t                smp_q;
	mar_pkg::pos_t                   wp_q;
	mar_pkg::sum_t                   sum_q;
	logic                            filled_q;
	mar_pkg::sample_t                held_q;
	logic [mar_pkg::CNT_BITS-1:0]    cnt_q;
	logic [mar_pkg::REM_BITS-1:0]    rem_q;
	mar_pkg::mag_t                   dvd_q;
	logic                            neg_q;
	logic                            upd_q;
	logic                            zero_q;
	logic                            res_valid_q;
	logic                            res_rdy_q;
	mar_pkg::sample_t                res_avg_q;

	// effective window length, saturated
	mar_pkg::wlen_t len;
	logic           len_zero;
	assign len      = (wl_q > mar_pkg::WL_BITS'(mar_pkg::MAX_WINDOW))
	                  ? mar_pkg::WL_BITS'(mar_pkg::MAX_WINDOW) : wl_q;
	assign len_zero = (len == '0);

	// handshakes
	logic in_fire, cfg_fire, out_free;
	assign samples.ready = (state_q == ST_IDLE);
	assign in_fire       = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;
	assign cfg_fire      = cfg.valid;
	assign out_free      = !res_valid_q || results.ready;

	// current and next write position
	mar_pkg::pos_t               wp_cur, wp_nxt;
	logic [mar_pkg::POS_BITS:0]  wp_inc;
	assign wp_cur = ({1'b0, wp_q} >= len) ? '0 : wp_q;
	assign wp_inc = {1'b0, wp_cur} + 1'b1;
	assign wp_nxt = (wp_inc >= len) ? '0 : wp_inc[mar_pkg::POS_BITS-1:0];

	// running sum update and its magnitude for the divider
	mar_pkg::sample_t old_smp;
	mar_pkg::sum_t    sum_nxt;
	mar_pkg::mag_t    mag_nxt;
	logic             filled_nxt;
	assign old_smp    = valid_q[wp_cur] ? rd_q : '0;
	assign sum_nxt    = sum_q + {{SX{smp_q[mar_pkg::SAMPLE_BITS-1]}}, smp_q}
	                  - {{SX{old_smp[mar_pkg::SAMPLE_BITS-1]}}, old_smp};
	assign mag_nxt    = sum_nxt[mar_pkg::SUM_BITS-1] ? mar_pkg::MAG_BITS'(-sum_nxt)
	                                                 : mar_pkg::MAG_BITS'(sum_nxt);
	assign filled_nxt = filled_q || (wp_nxt == '0);

	// one restoring step: shift in the next dividend bit, subtract if it fits
	logic [mar_pkg::REM_BITS:0] trial;
	logic                       fits;
	assign trial = {rem_q, dvd_q[mar_pkg::MAG_BITS-1]};
	assign fits  = (trial >= (mar_pkg::REM_BITS+1)'(len));

	// quotient with sign restored, low bits only
	mar_pkg::sample_t quo;
	mar_pkg::sample_t avg_nxt;
	assign quo     = neg_q ? mar_pkg::SAMPLE_BITS'(-dvd_q[mar_pkg::SAMPLE_BITS-1:0])
	                       : dvd_q[mar_pkg::SAMPLE_BITS-1:0];
	assign avg_nxt = zero_q ? '0 : (upd_q ? quo : held_q);

	// ring storage, no reset: valid bits mask unwritten entries
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_q  <= mem[wp_cur];
			smp_q <= samples.sample;
		end
		if (state_q == ST_READ) begin
			mem[wp_cur] <= smp_q;
		end
	end

	// sequencer, window state and divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			wl_q     <= mar_pkg::WL_BITS'(8);
			valid_q  <= '0;
			wp_q     <= '0;
			sum_q    <= '0;
			filled_q <= 1'b0;
			held_q   <= '0;
			cnt_q    <= '0;
			upd_q    <= 1'b0;
			zero_q   <= 1'b0;
		end else begin
			if (cfg_fire) begin
				wl_q     <= cfg.window_length;
				valid_q  <= '0;
				wp_q     <= '0;
				sum_q    <= '0;
				filled_q <= 1'b0;
				held_q   <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						zero_q  <= len_zero;
						upd_q   <= 1'b0;
						state_q <= len_zero ? ST_WAIT : ST_READ;
					end
				end
				ST_READ: begin
					valid_q[wp_cur] <= 1'b1;
					wp_q     <= wp_nxt;
					sum_q    <= sum_nxt;
					filled_q <= filled_nxt;
					upd_q    <= filled_nxt;
					cnt_q    <= mar_pkg::CNT_BITS'(mar_pkg::MAG_BITS - 1);
					state_q  <= filled_nxt ? ST_DIV : ST_WAIT;
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_free) begin
						if (upd_q && !zero_q) begin
							held_q <= quo;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// divider datapath, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			dvd_q <= mag_nxt;
			rem_q <= '0;
			neg_q <= sum_nxt[mar_pkg::SUM_BITS-1];
		end else if (state_q == ST_DIV) begin
			dvd_q <= {dvd_q[mar_pkg::MAG_BITS-2:0], fits};
			rem_q <= fits ? mar_pkg::REM_BITS'(trial - (mar_pkg::REM_BITS+1)'(len))
			              : trial[mar_pkg::REM_BITS-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == ST_WAIT && out_free) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && out_free) begin
			res_rdy_q <= zero_q ? 1'b0 : filled_q;
			res_avg_q <= avg_nxt;
		end
	end

	assign results.valid     = res_valid_q;
	assign results.ready_res = res_rdy_q;
	assign results.average   = res_avg_q;

	// checks
	`MAR_ASSERT_NXT(a_busy_after_take, in_fire, state_q != ST_IDLE, "sample taken while idle kept")
	`MAR_ASSERT_NXT(a_div_ends, (state_q == ST_DIV) && (cnt_q == '0), state_q == ST_WAIT, "divider overran")
	`MAR_ASSERT_IMP(a_rem_below_len, state_q == ST_DIV, rem_q < mar_pkg::REM_BITS'(len), "remainder not below window length")
	`MAR_ASSERT_IMP(a_unfilled_zero, !filled_q, held_q == '0, "held average nonzero before first wrap")
	`MAR_ASSERT_IMP(a_not_ready_zero, results.valid && !results.ready_res, results.average == '0, "average nonzero while not ready")

endmodule

`default_nettype wire
